// ----- design/sha256_pkg.sv -----
// Package for the SHA-256 stream hasher: round constants, initial words,
// round helper functions and the queue entry type. No dependencies.
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  localparam logic [255:0] InitWords = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    init_word = InitWords[255 - 32 * idx -: 32];
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    round_k = k[r];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- design/sha256_queue.sv -----
// Short queue between the input front and the hashing back end.
// Depends on sha256_pkg.
module sha256_queue #(
  parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  sha256_pkg::item_t   wr_item,
  output logic                rd_valid,
  input  logic                rd_ready,
  output sha256_pkg::item_t   rd_item
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha256_pkg::item_t  mem [Depth];
  logic [Aw-1:0]      wptr;
  logic [Aw-1:0]      rptr;
  logic [Aw:0]        count;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = count != Depth[Aw:0];
  assign rd_valid = count != '0;
  assign rd_item  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_item;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == Aw'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == Aw'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + {{Aw{1'b0}}, do_wr} - {{Aw{1'b0}}, do_rd};
    end
  end
endmodule

// ----- design/sha256_core.sv -----
// Back end: gathers bytes into blocks, pads, runs one round per cycle
// and emits the digest words. Depends on sha256_pkg.
module sha256_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha256_pkg::item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_word,
  output logic [2:0]        out_index,
  output logic              out_last
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ROUND = 6'b000100,
    S_FOLD  = 6'b001000,
    S_PAD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t       state;
  logic [31:0]  hv [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [31:0]  blk [16];
  logic [63:0]  length_bits;
  logic [6:0]   fill;
  logic [5:0]   rnd;
  logic [3:0]   ld;
  logic         pad_pending;
  logic         out_after;
  logic [2:0]   oidx;
  logic [31:0]  wv;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  x15;
  logic [31:0]  x2;
  logic [31:0]  ws;
  logic [7:0]   pad_byte;
  logic         mid_pad;
  logic         mid_pad_set;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = sha256_pkg::ror(x, n);
  endfunction

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign out_word  = hv[oidx];
  assign out_index = oidx;
  assign out_last  = oidx == 3'd7;

  always_comb begin
    x15 = w[1];
    x2  = w[14];
    ws  = w[0] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[9]
        + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
    wv  = (rnd < 6'd16) ? w[0] : ws;
    t1  = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
        + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(rnd) + wv;
    t2  = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
        + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    if (fill[5:0] >= 6'd56) begin
      pad_byte = length_bits[8 * (63 - fill[5:0]) +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_item.has_byte) begin
      blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= in_item.data_byte;
    end else if (state == S_PAD) begin
      if (pad_pending) begin
        blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= 8'h80;
      end else begin
        blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <=
            (fill[5:0] >= 6'd56 && !out_after) ? 8'h00 : pad_byte;
      end
    end
    if (state == S_LOAD) begin
      for (int j = 0; j < 15; j++) begin
        w[j] <= w[j+1];
      end
      w[15] <= blk[ld];
    end else if (state == S_ROUND) begin
      for (int j = 0; j < 15; j++) begin
        w[j] <= w[j+1];
      end
      w[15] <= (rnd < 6'd16) ? w[0] : ws;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      length_bits <= '0;
      rnd         <= '0;
      ld          <= '0;
      oidx        <= '0;
      pad_pending <= 1'b0;
      out_after   <= 1'b0;
      for (int j = 0; j < 8; j++) begin
        hv[j] <= sha256_pkg::init_word(3'(j));
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.has_byte) begin
              length_bits <= length_bits + 64'd8;
              fill        <= fill + 7'd1;
            end
            pad_pending <= in_item.end_of_message;
            out_after   <= 1'b0;
            if (in_item.has_byte && fill == 7'd63) begin
              state <= S_LOAD;
              ld    <= '0;
            end else if (in_item.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill <= fill + 7'd1;
          if (pad_pending) begin
            pad_pending <= 1'b0;
            out_after   <= fill < 7'd56;
          end else if (fill == 7'd56) begin
            out_after <= 1'b1;
          end
          if (fill == 7'd63) begin
            state <= S_LOAD;
            ld    <= '0;
          end
        end
        S_LOAD: begin
          ld <= ld + 4'd1;
          if (ld == 4'd15) begin
            state <= S_ROUND;
            rnd   <= '0;
            for (int j = 0; j < 8; j++) begin
              v[j] <= hv[j];
            end
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          fill <= '0;
          for (int j = 0; j < 8; j++) begin
            hv[j] <= hv[j] + v[j];
          end
          if (out_after) begin
            state <= S_OUT;
            oidx  <= '0;
          end else if (pad_pending || mid_pad) begin
            state     <= S_PAD;
            out_after <= mid_pad;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state       <= S_IDLE;
              length_bits <= '0;
              fill        <= '0;
              out_after   <= 1'b0;
              for (int j = 0; j < 8; j++) begin
                hv[j] <= sha256_pkg::init_word(3'(j));
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mid_pad_set = (state == S_PAD) && (fill == 7'd63) && !out_after
                       && !(pad_pending && fill < 7'd56);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_pad <= 1'b0;
    end else if (mid_pad_set) begin
      mid_pad <= 1'b1;
    end else if (state == S_FOLD) begin
      mid_pad <= 1'b0;
    end
  end
endmodule

// ----- design/sha256_stream_hasher.sv -----
// SHA-256 stream hasher top level: input queue feeding the hashing core.
// Depends on sha256_pkg, sha256_queue and sha256_core.
// A beat passes through the registered queue; a byte that fills a block starts the
// load, round and fold steps. An end mark pads out the bytes left in the block, with
// a second block when the length does not fit, then eight digest beats. The core
// takes no bytes while a block is hashed. Reset is synchronous and restarts the hash.
module sha256_stream_hasher #(
  parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // data_byte
  input  logic        s_tuser,  // has_byte
  input  logic        s_tlast,  // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // digest_word, word_index, zero fill
  output logic        m_tlast   // last_word
);
  sha256_pkg::item_t q_in;
  sha256_pkg::item_t q_out;
  logic              q_valid;
  logic              q_ready;
  logic [31:0]       word;
  logic [2:0]        idx;

  assign q_in = '{data_byte: s_tdata, has_byte: s_tuser, end_of_message: s_tlast};

  sha256_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_item(q_in),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_out)
  );

  sha256_core u_core (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_out),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_word(word), .out_index(idx), .out_last(m_tlast)
  );

  assign m_tdata = {5'd0, idx, word};
endmodule

// ----- verif/sha256_stream_hasher_tb.sv -----
// Testbench for sha256_stream_hasher: drives byte beats, predicts each digest
// with its own SHA-256 model and checks every digest beat. Depends on the RTL.
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  class digest_scoreboard;
    logic [31:0]  chain [8];
    logic [7:0]   block [64];
    logic [63:0]  bit_count;
    int           fill;
    digest_beat_t awaited [$];
    int           fails;

    function new();
      fails = 0;
      restart();
    endfunction

    function void restart();
      chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      bit_count = '0;
      fill = 0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] k [64];
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      k = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      for (int j = 0; j < 16; j++) begin
        w[j] = {block[4*j], block[4*j+1], block[4*j+2], block[4*j+3]};
      end
      for (int j = 16; j < 64; j++) begin
        s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
        s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
        w[j] = w[j-16] + s0 + w[j-7] + s1;
      end
      v = chain;
      for (int r = 0; r < 64; r++) begin
        s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[r] + w[r];
        s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) chain[j] += v[j];
    endfunction

    function void note_input(logic [7:0] data, logic has, logic eom);
      digest_beat_t b;
      if (has) begin
        block[fill] = data;
        fill++;
        bit_count += 8;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!eom) return;
      block[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        while (fill < 64) block[fill++] = 8'h00;
        compress();
        fill = 0;
      end
      while (fill < 56) block[fill++] = 8'h00;
      for (int j = 0; j < 8; j++) block[63-j] = bit_count[8*j +: 8];
      compress();
      for (int j = 0; j < 8; j++) begin
        b.word = chain[j];
        b.index = j[2:0];
        b.last = (j == 7);
        awaited.push_back(b);
      end
      restart();
    endfunction

    function void check_result(logic [39:0] data, logic last);
      digest_beat_t e;
      if (awaited.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected digest beat %h last %b", data, last);
        return;
      end
      e = awaited.pop_front();
      if (data[31:0] !== e.word || data[34:32] !== e.index || data[39:35] !== 5'd0 ||
          last !== e.last) begin
        fails++;
        if (fails <= 10) begin
          $display("digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
                   e.word, e.index, e.last, data[31:0], data[34:32], last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  digest_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int cycles = 0;

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  task automatic send_beat(logic [7:0] data, logic has, logic eom);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= has;
    s_tlast <= eom;
    do @(posedge clk); while (!s_tready);
    sb.note_input(data, has, eom);
    items_sent++;
  endtask

  task automatic send_message(int len, logic end_has_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, 1'b0);
    end
    send_beat(8'($urandom), end_has_byte, 1'b1);
  endtask

  task automatic random_message();
    int pick;
    int len;
    pick = $urandom_range(9);
    case (pick)
      0: len = 54 + $urandom_range(3);
      1: len = 62 + $urandom_range(3);
      2: len = 118 + $urandom_range(3);
      default: len = $urandom_range(12);
    endcase
    send_message(len, 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 36;
    recv_stall_pct = 52;
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b0);
    send_beat(8'h55, 1'b0, 1'b1);
    send_beat(8'haa, 1'b1, 1'b0);
    send_beat(8'h7e, 1'b1, 1'b1);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 52 : 0;
      recv_stall_pct = (phase == 0) ? 52 : (phase == 1) ? 36 : 0;
      while (items_sent < 10 + 45 * (phase + 1)) random_message();
      if (phase == 1) begin
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.fails == 0 && sb.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
